>>> rtl/lrbh_pkg.sv
package lrbh_pkg;

  // Field and register widths.
  localparam int BLK_LEN_W   = 14;
  localparam int TOP_W       = 3;
  localparam int TOTAL_W     = 8;
  localparam int MIN_RUN_W   = 6;
  localparam int COUNT_W     = 8;
  localparam int RUN_W       = 14;
  localparam int CFG_DATA_W  = 14;
  localparam int CFG_IDX_W   = 2;

  // Defaults for the top-level parameters.
  localparam int MAX_BINS_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register reset values.
  localparam logic [BLK_LEN_W-1:0] BLK_LEN_RST   = BLK_LEN_W'(8);
  localparam logic [TOP_W-1:0]     TOP_RST       = TOP_W'(3);
  localparam logic [TOTAL_W-1:0]   TOTAL_RST     = TOTAL_W'(16);
  localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST   = MIN_RUN_W'(1);

  localparam logic [RUN_W-1:0]     RUN_MAX       = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_CATEGORY_TOP = 2'd1,
    REG_BLOCK_TOTAL  = 2'd2,
    REG_MIN_RUN      = 2'd3
  } cfg_reg_t;

  // One queued event from the front end: a finished block with its bin,
  // and/or the end of the sequence.
  typedef struct packed {
    logic             close;
    logic [TOP_W-1:0] bin;
    logic             eos;
  } evt_t;

endpackage

>>> rtl/lrbh_front.sv
module lrbh_front
  import lrbh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 seq_bit,
  input  logic                 end_of_sequence,
  input  logic [BLK_LEN_W-1:0] block_length,
  input  logic [TOTAL_W-1:0]   block_total,
  input  logic [MIN_RUN_W-1:0] min_run,
  input  logic [TOP_W-1:0]     top_bin,
  output logic                 push,
  output evt_t                 evt
);

  logic [BLK_LEN_W-1:0] pos_r, pos_nxt;
  logic [TOTAL_W-1:0]   blocks_r, blocks_nxt;
  logic [RUN_W-1:0]     cur_r, cur_nxt;
  logic [RUN_W-1:0]     long_r, long_nxt;
  logic [RUN_W-1:0]     cur_inc, long_upd;
  logic [BLK_LEN_W-1:0] pos_inc, len;
  logic [RUN_W-1:0]     hi_edge;
  logic                 counting, close;
  logic [TOP_W-1:0]     bin;

  assign len      = (block_length == '0) ? BLK_LEN_W'(1) : block_length;
  assign counting = (blocks_r < block_total);
  assign cur_inc  = seq_bit ? ((cur_r == RUN_MAX) ? cur_r : cur_r + 1'b1) : '0;
  assign long_upd = (cur_inc > long_r) ? cur_inc : long_r;
  assign pos_inc  = pos_r + 1'b1;
  assign close    = accept && counting && ((pos_inc >= len) || (pos_inc == '0));
  assign hi_edge  = RUN_W'(min_run) + RUN_W'(top_bin);

  // Category of the block that closes on this bit.
  always_comb begin
    if (long_upd <= RUN_W'(min_run)) begin
      bin = '0;
    end else if (long_upd >= hi_edge) begin
      bin = top_bin;
    end else begin
      bin = TOP_W'(long_upd - RUN_W'(min_run));
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    blocks_nxt = blocks_r;
    cur_nxt    = cur_r;
    long_nxt   = long_r;
    if (accept && counting) begin
      cur_nxt  = cur_inc;
      long_nxt = long_upd;
      pos_nxt  = pos_inc;
      if (close) begin
        pos_nxt    = '0;
        cur_nxt    = '0;
        long_nxt   = '0;
        blocks_nxt = blocks_r + 1'b1;
      end
    end
    if (accept && end_of_sequence) begin
      pos_nxt    = '0;
      blocks_nxt = '0;
      cur_nxt    = '0;
      long_nxt   = '0;
    end
  end

  assign push      = close || (accept && end_of_sequence);
  assign evt.close = close;
  assign evt.bin   = bin;
  assign evt.eos   = end_of_sequence;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      blocks_r <= '0;
      cur_r    <= '0;
      long_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      blocks_r <= blocks_nxt;
      cur_r    <= cur_nxt;
      long_r   <= long_nxt;
    end
  end

endmodule

>>> rtl/lrbh_fifo.sv
module lrbh_fifo
  import lrbh_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_evt,
  input  logic pop,
  output evt_t head_evt,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_evt = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lrbh_back.sv
module lrbh_back
  import lrbh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TOP_W-1:0]   top_bin,
  input  evt_t               head_evt,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOP_W-1:0]   out_bin_index,
  output logic [COUNT_W-1:0] out_bin_count,
  output logic               out_last_bin
);

  localparam int BW = $clog2(MAX_BINS);

  typedef enum logic {ST_RUN, ST_EMIT} state_t;

  state_t             state_r;
  logic [BW-1:0]      idx_r;
  logic [COUNT_W-1:0] counts_r [MAX_BINS];
  logic [BW-1:0]      rd_addr;
  logic [COUNT_W-1:0] rd_cnt;
  logic               idx_last;
  logic               load;

  // Single read port into the bin counters: the emit index while
  // draining, the incoming event's bin otherwise.
  assign rd_addr  = (state_r == ST_EMIT) ? idx_r : BW'(head_evt.bin);
  assign rd_cnt   = counts_r[rd_addr];
  assign idx_last = (idx_r == BW'(top_bin));
  assign pop      = (state_r == ST_RUN) && !empty;
  assign load     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_RUN;
      idx_r     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_BINS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      // While draining, an accepted result is replaced by the next one below.
      if (out_valid && out_ready && (state_r != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (!empty) begin
            if (head_evt.close && (rd_cnt != COUNT_MAX)) begin
              counts_r[rd_addr] <= rd_cnt + 1'b1;
            end
            if (head_evt.eos) begin
              state_r <= ST_EMIT;
              idx_r   <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid     <= 1'b1;
            out_bin_index <= TOP_W'(idx_r);
            out_bin_count <= rd_cnt;
            out_last_bin  <= idx_last;
            if (idx_last) begin
              state_r <= ST_RUN;
              for (int i = 0; i < MAX_BINS; i++) begin
                counts_r[i] <= '0;
              end
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

endmodule

>>> rtl/longest_run_block_histogram_unit.sv
// Longest-run-of-ones block histogram, counting stage of the longest run of
// ones in a block randomness test.
// Input channel (in_valid/in_ready): one sequence bit per transaction, with
// in_end_of_sequence set on the final bit. The unit takes one bit every
// clock cycle; in_ready drops only while the event queue between the front
// and back ends is full, which happens when a histogram is being drained.
// Output channel (out_valid/out_ready): after an end-of-sequence transaction
// the unit emits one transaction per bin, bins 0 up to category_top (capped
// at MAX_BINS-1) in order, out_last_bin set on the last. The end-of-sequence
// event passes through the event queue and the back end's emit state before
// out_valid rises; results then follow one per cycle while out_ready is high.
// When the receiver stalls, the result is held and the back end waits; the
// front end keeps taking bits until the queue fills.
// Configuration (cfg_we/cfg_index/cfg_wdata) is for the user to write while
// idle only; the unit does not enforce it. Reset (rst_n, synchronous) restores
// the register defaults and clears all counters; no clearing pass is needed.
module longest_run_block_histogram_unit
  import lrbh_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_seq_bit,
  input  logic                  in_end_of_sequence,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TOP_W-1:0]      out_bin_index,
  output logic [COUNT_W-1:0]    out_bin_count,
  output logic                  out_last_bin,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TOP_LIMIT = MAX_BINS - 1;

  // Configuration registers.
  logic [BLK_LEN_W-1:0] block_length_r;
  logic [TOP_W-1:0]     category_top_r;
  logic [TOTAL_W-1:0]   block_total_r;
  logic [MIN_RUN_W-1:0] min_run_r;

  logic [TOP_W-1:0] top_bin;
  logic             accept;
  logic             push, pop, q_full, q_empty;
  evt_t             push_evt, head_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= BLK_LEN_RST;
      category_top_r <= TOP_RST;
      block_total_r  <= TOTAL_RST;
      min_run_r      <= MIN_RUN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_LENGTH: block_length_r <= cfg_wdata[BLK_LEN_W-1:0];
        REG_CATEGORY_TOP: category_top_r <= cfg_wdata[TOP_W-1:0];
        REG_BLOCK_TOTAL:  block_total_r  <= cfg_wdata[TOTAL_W-1:0];
        REG_MIN_RUN:      min_run_r      <= cfg_wdata[MIN_RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // The highest bin cannot exceed the number of counters provided.
  assign top_bin = (int'(category_top_r) > TOP_LIMIT) ? TOP_W'(TOP_LIMIT)
                                                      : category_top_r;

  // The front end needs no back-pressure beyond a free queue slot.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  lrbh_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .seq_bit         (in_seq_bit),
    .end_of_sequence (in_end_of_sequence),
    .block_length    (block_length_r),
    .block_total     (block_total_r),
    .min_run         (min_run_r),
    .top_bin         (top_bin),
    .push            (push),
    .evt             (push_evt)
  );

  lrbh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .full     (q_full),
    .empty    (q_empty)
  );

  lrbh_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .top_bin       (top_bin),
    .head_evt      (head_evt),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_bin_count (out_bin_count),
    .out_last_bin  (out_last_bin)
  );

`ifndef SYNTHESIS
  // A drain always starts with bin zero.
  a_first_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_bin_index == '0))
    else $error("histogram drain did not start at bin zero");

  // The last flag marks exactly the highest bin.
  a_last_matches_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_bin == (out_bin_index == top_bin)))
    else $error("last bin flag does not match the highest bin");

  // The queue can never report full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("event queue is both full and empty");

  // A result accepted without the last flag is followed by the next bin.
  a_bins_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_bin) |=>
      (out_valid && (out_bin_index == $past(out_bin_index) + 1'b1)))
    else $error("histogram bins out of order");
`endif

endmodule
